// ===== design/segtl_pkg.sv =====
// ----------------------------------------------------------------------------
// segtl_pkg
// Shared types and constants of the segment timeline index.
// ----------------------------------------------------------------------------
`default_nettype none
package segtl_pkg;

    localparam int TableDepthDefault = 64;
    localparam int EntryW = 128;

    typedef enum logic [1:0] {
        K_APPEND = 2'd0,
        K_T2N    = 2'd1,
        K_N2T    = 2'd2,
        K_PRUNE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_EVAL,
        S_DIV,
        S_WR,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ===== design/segtl_ram.sv =====
// ----------------------------------------------------------------------------
// segtl_ram
// Run table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module segtl_ram
    import segtl_pkg::*;
#(
    parameter int DEPTH = TableDepthDefault,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [EntryW-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [EntryW-1:0] o_rdata
);

    logic [EntryW-1:0] r_mem [DEPTH];
    logic [EntryW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/segtl_div.sv =====
// ----------------------------------------------------------------------------
// segtl_div
// Serial restoring divider, one quotient bit per cycle, 32-bit quotient.
// The caller guarantees the quotient fits in 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module segtl_div
    import segtl_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic      [31:0] o_quot
);

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [4:0]  r_step, n_step;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_low, n_low;
    logic [31:0] r_q, n_q;
    logic [31:0] r_d, n_d;
    logic [32:0] rem_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_low  = r_low;
        n_q    = r_q;
        n_d    = r_d;
        rem_sh = {r_rem[31:0], r_low[31]};
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 5'd0;
            n_rem  = {1'b0, i_dividend[63:32]};
            n_low  = i_dividend[31:0];
            n_d    = i_divisor;
        end else if (r_busy) begin
            if (rem_sh >= {1'b0, r_d}) begin
                n_rem = rem_sh - {1'b0, r_d};
                n_q   = {r_q[30:0], 1'b1};
            end else begin
                n_rem = rem_sh;
                n_q   = {r_q[30:0], 1'b0};
            end
            n_low  = {r_low[30:0], 1'b0};
            n_step = r_step + 5'd1;
            if (r_step == 5'd31) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_rem <= n_rem;
        r_low <= n_low;
        r_q   <= n_q;
        r_d   <= n_d;
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ===== design/segment_timeline_index_top.sv =====
// ----------------------------------------------------------------------------
// segment_timeline_index_top
// Bounded circular table of timed segment runs with append, time to number,
// number to time and prune operations.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake              Payload
//  s_axis    in   i_s_tvalid/o_s_tready  tuser: kind; tdata: time, dur, rep, num
//  m_axis    out  o_m_tvalid/i_m_tready  tdata: number, time, removed, dropped
//
// One item is handled at a time. An append writes its run directly, or first
// reads the previous run when it follows on from it (one table read). A query
// walks the held runs through the single read port, one run at a time through
// the read, multiply and evaluate states; a time query that ends inside a run
// also waits for the serial divider. A prune reads and examines each run in
// turn the same way. Reset is synchronous and clears only the head, fill count,
// pruned total and control; the table is never cleared, since only written
// entries are read. A finished result waits in the output register, and the next item is accepted while it waits.
// ----------------------------------------------------------------------------
`default_nettype none
module segment_timeline_index_top
    import segtl_pkg::*;
#(
    parameter int TABLE_DEPTH = TableDepthDefault
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // tdata: time_value[63:0], duration[95:64], repeat_count[127:96],
    //        segment_number[175:128]
    input  wire logic [175:0] i_s_tdata,
    // tuser: kind[1:0]
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // tdata: result_number[47:0], result_time[111:48], removed_count[159:112],
    //        dropped[160], zero fill [167:161]
    output logic      [167:0] o_m_tdata
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW:0] DepthW = (CW + 1)'(TABLE_DEPTH);

    // Control and working registers.
    t_state       r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_fill, n_fill;
    logic [47:0]  r_pruned, n_pruned;
    t_kind        r_kind, n_kind;
    logic [63:0]  r_tv, n_tv;
    logic [31:0]  r_dur, n_dur;
    logic [31:0]  r_rep, n_rep;
    logic [63:0]  r_t, n_t;      // remaining time, or start for a write
    logic [47:0]  r_cnt, n_cnt;  // segments counted or removed
    logic [47:0]  r_n, n_n;      // remaining number for a number query
    logic [CW-1:0] r_idx, n_idx;
    logic [63:0]  r_prod, n_prod;
    logic [63:0]  r_prod2, n_prod2;
    logic [63:0]  r_rtime, n_rtime;
    logic         r_drop, n_drop;
    logic         r_out_valid, n_out_valid;
    logic [167:0] r_out_data, n_out_data;

    // Table and divider hookup.
    logic              ram_we, ram_re;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [EntryW-1:0] ram_wdata, ram_rdata;
    logic              div_start, div_done;
    logic [31:0]       div_quot;

    logic [63:0] rd_start;
    logic [31:0] rd_dur, rd_rep;
    logic [63:0] full_len, end_time;
    logic [47:0] reps;
    logic [CW:0] rd_sum, wr_sum;
    logic [AW-1:0] rd_slot, wr_slot;
    logic [CW-1:0] idx_next;
    logic [47:0] out_number, out_removed;

    assign rd_start = ram_rdata[127:64];
    assign rd_dur   = ram_rdata[63:32];
    assign rd_rep   = ram_rdata[31:0];
    assign full_len = r_prod + {32'd0, rd_dur};
    assign end_time = rd_start + full_len;
    assign reps     = {16'd0, rd_rep} + 48'd1;
    assign idx_next = r_idx + CW'(1);

    // Slots wrap modulo the table depth, which need not be a power of two.
    assign rd_sum  = (CW + 1)'(r_head) + {1'b0, r_idx};
    assign rd_slot = (rd_sum >= DepthW) ? AW'(rd_sum - DepthW) : AW'(rd_sum);
    assign wr_sum  = (CW + 1)'(r_head) + {1'b0, r_fill};
    assign wr_slot = (wr_sum >= DepthW) ? AW'(wr_sum - DepthW) : AW'(wr_sum);

    assign out_number  = (r_kind == K_T2N) ? (r_cnt + r_pruned) : 48'd0;
    assign out_removed = (r_kind == K_PRUNE) ? r_cnt : 48'd0;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_fill      = r_fill;
        n_pruned    = r_pruned;
        n_kind      = r_kind;
        n_tv        = r_tv;
        n_dur       = r_dur;
        n_rep       = r_rep;
        n_t         = r_t;
        n_cnt       = r_cnt;
        n_n         = r_n;
        n_idx       = r_idx;
        n_prod      = r_prod;
        n_prod2     = r_prod2;
        n_rtime     = r_rtime;
        n_drop      = r_drop;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = wr_slot;
        ram_raddr   = rd_slot;
        ram_wdata   = {r_t, r_dur, r_rep};
        div_start   = 1'b0;
        o_s_tready  = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_kind  = t_kind'(i_s_tuser);
                    n_tv    = i_s_tdata[63:0];
                    n_dur   = i_s_tdata[95:64];
                    n_rep   = i_s_tdata[127:96];
                    n_t     = i_s_tdata[63:0];
                    n_n     = i_s_tdata[175:128];
                    n_cnt   = 48'd0;
                    n_idx   = '0;
                    n_rtime = 64'd0;
                    n_drop  = 1'b0;
                    n_state = S_OUT;
                    case (t_kind'(i_s_tuser))
                        K_APPEND: begin
                            if ({1'b0, r_fill} == DepthW) begin
                                n_drop = 1'b1;
                            end else if (r_fill != '0 && i_s_tdata[63:0] == 64'd0) begin
                                n_idx   = r_fill - CW'(1);
                                n_state = S_RD;
                            end else begin
                                n_state = S_WR;
                            end
                        end
                        K_T2N: begin
                            if ($signed(i_s_tdata[63:0]) > 64'sd0 && r_fill != '0) begin
                                n_state = S_RD;
                            end
                        end
                        K_N2T: begin
                            n_n = i_s_tdata[175:128] - r_pruned;
                            if (i_s_tdata[175:128] >= r_pruned && r_fill != '0) begin
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            if (r_fill != '0) begin
                                n_state = S_RD;
                            end
                        end
                    endcase
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_prod  = {32'd0, rd_dur} * {32'd0, rd_rep};
                n_prod2 = {32'd0, r_n[31:0]} * {32'd0, rd_dur};
                n_state = S_EVAL;
            end
            S_EVAL: begin
                case (r_kind)
                    K_APPEND: begin
                        n_t     = end_time;
                        n_state = S_WR;
                    end
                    K_T2N: begin
                        if (rd_dur != 32'd0 && r_t <= full_len) begin
                            div_start = 1'b1;
                            n_state   = S_DIV;
                        end else begin
                            n_cnt = r_cnt + reps;
                            if (rd_dur != 32'd0) begin
                                n_t = r_t - full_len;
                            end
                            n_idx   = idx_next;
                            n_state = (idx_next == r_fill) ? S_OUT : S_RD;
                        end
                    end
                    K_N2T: begin
                        if (r_n == 48'd0) begin
                            n_rtime = rd_start;
                            n_state = S_OUT;
                        end else if (r_n <= {16'd0, rd_rep}) begin
                            n_rtime = rd_start + r_prod2;
                            n_state = S_OUT;
                        end else begin
                            n_n     = r_n - reps;
                            n_idx   = idx_next;
                            n_state = (idx_next == r_fill) ? S_OUT : S_RD;
                        end
                    end
                    default: begin
                        if ($signed(end_time) < $signed(r_tv)) begin
                            n_cnt   = r_cnt + reps;
                            n_head  = (r_head == AW'(TABLE_DEPTH - 1)) ? '0
                                                                        : r_head + AW'(1);
                            n_fill  = r_fill - CW'(1);
                            n_state = (r_fill == CW'(1)) ? S_OUT : S_RD;
                        end else begin
                            n_state = S_OUT;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (div_done) begin
                    n_cnt   = r_cnt + {16'd0, div_quot};
                    n_state = S_OUT;
                end
            end
            S_WR: begin
                ram_we  = 1'b1;
                n_fill  = r_fill + CW'(1);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {7'd0, r_drop, out_removed, r_rtime, out_number};
                    if (r_kind == K_PRUNE) begin
                        n_pruned = r_pruned + r_cnt;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_fill      <= '0;
            r_pruned    <= 48'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_pruned    <= n_pruned;
            r_out_valid <= n_out_valid;
        end
        r_kind     <= n_kind;
        r_tv       <= n_tv;
        r_dur      <= n_dur;
        r_rep      <= n_rep;
        r_t        <= n_t;
        r_cnt      <= n_cnt;
        r_n        <= n_n;
        r_idx      <= n_idx;
        r_prod     <= n_prod;
        r_prod2    <= n_prod2;
        r_rtime    <= n_rtime;
        r_drop     <= n_drop;
        r_out_data <= n_out_data;
    end

    segtl_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // The remaining time is positive here, so the dividend never underflows.
    segtl_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_t - 64'd1),
        .i_divisor  (rd_dur),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fill} <= DepthW)
        else $error("fill count beyond table depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CW + 1)'(r_head) < DepthW)
        else $error("head slot beyond table depth");

    a_div_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_kind == K_T2N))
        else $error("divider busy outside a time query");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, r_fill} < DepthW))
        else $error("table write with the table full");

endmodule
`default_nettype wire
